/* hdl/spatial_lp_pooling_top_defines.svh */
// Assertion macros shared by the spatial Lp pooling RTL.
`ifndef SPATIAL_LP_POOLING_TOP_DEFINES_SVH
`define SPATIAL_LP_POOLING_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPLP_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lp pool: same-cycle check failed");
`define SPLP_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lp pool: next-cycle check failed");
`else
`define SPLP_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define SPLP_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* hdl/splp_pkg.sv */
// Package with constants, types and helper functions of the Lp pooling block.
`default_nettype none
package splp_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SAMPLE_BITS = 16;
    localparam int ROOT_BITS   = 20;
    localparam int BIT_IDX_W   = $clog2(ROOT_BITS);
    localparam int SUM_BITS    = 64;
    localparam int IW_BITS     = 11;
    localparam int SMALL_BITS  = 3;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam logic [SMALL_BITS-1:0] SMALL_MAX = 3'd4;

    localparam logic [IW_BITS-1:0]    IMAGE_WIDTH_RST = 11'd64;
    localparam logic [SMALL_BITS-1:0] POOL_WIDTH_RST  = 3'd2;
    localparam logic [SMALL_BITS-1:0] POOL_HEIGHT_RST = 3'd2;
    localparam logic [SMALL_BITS-1:0] P_ORDER_RST     = 3'd2;

    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_POOL_WIDTH  = 2'd1;
    localparam logic [1:0] REG_POOL_HEIGHT = 2'd2;
    localparam logic [1:0] REG_P_ORDER     = 2'd3;

    localparam logic [SMALL_BITS-1:0] P_ONE   = 3'd1;
    localparam logic [SMALL_BITS-1:0] P_TWO   = 3'd2;
    localparam logic [SMALL_BITS-1:0] P_THREE = 3'd3;
    localparam logic [SMALL_BITS-1:0] P_FOUR  = 3'd4;

    typedef struct packed {
        logic [SUM_BITS-1:0] value;
        logic                over;
    } t_pow;

    function automatic logic [SMALL_BITS-1:0] clamp_small(input logic [SMALL_BITS-1:0] v);
        logic [SMALL_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = SMALL_BITS'(1);
        end else if (v > SMALL_MAX) begin
            r = SMALL_MAX;
        end
        return r;
    endfunction

    function automatic logic [IW_BITS-1:0] clamp_width(input logic [IW_BITS-1:0] v);
        logic [IW_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = IW_BITS'(1);
        end else if (v > IW_BITS'(MAX_WIDTH)) begin
            r = IW_BITS'(MAX_WIDTH);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/splp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module splp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

/* hdl/splp_power.sv */
// Two-stage power unit: base^p for p of 1 to 4, with overflow beyond 64 bits.
`default_nettype none
module splp_power (
    input  wire logic                                 i_clk,
    input  wire logic [splp_pkg::ROOT_BITS-1:0]       i_base,
    input  wire logic [splp_pkg::SMALL_BITS-1:0]      i_p,
    output splp_pkg::t_pow                            o_res
);
    localparam int SQ_BITS = 2 * splp_pkg::ROOT_BITS;
    localparam int CU_BITS = 3 * splp_pkg::ROOT_BITS;
    localparam int HALF    = splp_pkg::SUM_BITS / 2;

    logic [splp_pkg::ROOT_BITS-1:0] r_base;
    logic [SQ_BITS-1:0]             r_sq;
    splp_pkg::t_pow                 r_res;
    splp_pkg::t_pow                 n_res;
    logic [CU_BITS-1:0]             cube;
    logic [splp_pkg::SUM_BITS-1:0]  quad;

    always_comb begin
        cube = CU_BITS'(r_sq) * CU_BITS'(r_base);
        quad = splp_pkg::SUM_BITS'(r_sq[HALF-1:0]) * splp_pkg::SUM_BITS'(r_sq[HALF-1:0]);
        n_res.over = 1'b0;
        case (i_p)
            splp_pkg::P_ONE: begin
                n_res.value = splp_pkg::SUM_BITS'(r_base);
            end
            splp_pkg::P_TWO: begin
                n_res.value = splp_pkg::SUM_BITS'(r_sq);
            end
            splp_pkg::P_THREE: begin
                n_res.value = splp_pkg::SUM_BITS'(cube);
            end
            splp_pkg::P_FOUR: begin
                // The fourth power reaches 2^64 exactly when the square reaches 2^32.
                n_res.value = quad;
                n_res.over  = |r_sq[SQ_BITS-1:HALF];
            end
            default: begin
                n_res.value = splp_pkg::SUM_BITS'(r_base);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_base <= i_base;
        r_sq   <= SQ_BITS'(i_base) * SQ_BITS'(i_base);
        r_res  <= n_res;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

/* hdl/spatial_lp_pooling_top.sv */
// Top level of the spatial Lp-norm pooling block.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_sample, i_last_of_plane
//  output    out        o_valid / i_ready    o_pooled, o_saturated, o_last_of_plane_out
//  config    in         APB psel/penable     paddr, pwdata, prdata
//
// An item that does not close a window passes through accept with the sum read,
// power of the magnitude, then saturating add and write-back.
// An item that closes a window then runs the 20-bit root search: per bit a square,
// power and compare step in the shared two-stage power unit, then the result is loaded.
// The result register lets the next item start while a result waits for i_ready;
// a second result waits in the load step until the register is free.
// Reset clears state, position counters and o_valid; the sum memory needs no clearing.
`default_nettype none
`include "spatial_lp_pooling_top_defines.svh"
module spatial_lp_pooling_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [splp_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                 i_last_of_plane,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic      [splp_pkg::ROOT_BITS-1:0]       o_pooled,
    output logic                                      o_saturated,
    output logic                                      o_last_of_plane_out,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [splp_pkg::PADDR_BITS-1:0]      paddr,
    input  wire logic [splp_pkg::PDATA_BITS-1:0]      pwdata,
    output logic      [splp_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                      pready
);
    localparam int COL_BITS = splp_pkg::COL_BITS;
    localparam int INC_BITS = COL_BITS + 3;
    localparam int SUM_BITS = splp_pkg::SUM_BITS;
    localparam int RB       = splp_pkg::ROOT_BITS;
    localparam int SB       = splp_pkg::SMALL_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_POW  = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_RSQ  = 7'b0001000,
        S_RPW  = 7'b0010000,
        S_RCMP = 7'b0100000,
        S_LOAD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [splp_pkg::IW_BITS-1:0] r_image_width;
    logic [SB-1:0]                r_pool_width, r_pool_height, r_p_order;
    logic [splp_pkg::IW_BITS-1:0] iw_c;
    logic [SB-1:0]                pw_c, ph_c, p_c;

    logic [COL_BITS-1:0]           r_column_count, n_column_count;
    logic [1:0]                    r_window_row, n_window_row;
    logic [1:0]                    r_window_column, n_window_column;

    logic                          r_last;
    logic [SUM_BITS-1:0]           r_old, r_acc;
    logic [RB-1:0]                 r_root;
    logic [splp_pkg::BIT_IDX_W-1:0] r_bit;

    logic                          r_out_valid;
    logic [RB-1:0]                 r_pooled;
    logic                          r_sat, r_last_out;

    logic                          cfg_wr, accept, out_free, win_done;
    logic                          row_end, col_done, row_done;
    logic [INC_BITS-1:0]           incol;
    logic [splp_pkg::SAMPLE_BITS-1:0] mag;
    logic [RB-1:0]                 cand, pow_base;
    logic [SUM_BITS:0]             sum_ext;
    logic [SUM_BITS-1:0]           acc_sat, ram_rd_data;
    logic                          root_ok;
    splp_pkg::t_pow                pow_res;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= splp_pkg::IMAGE_WIDTH_RST;
            r_pool_width  <= splp_pkg::POOL_WIDTH_RST;
            r_pool_height <= splp_pkg::POOL_HEIGHT_RST;
            r_p_order     <= splp_pkg::P_ORDER_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                splp_pkg::REG_IMAGE_WIDTH: r_image_width <= pwdata[splp_pkg::IW_BITS-1:0];
                splp_pkg::REG_POOL_WIDTH:  r_pool_width  <= pwdata[SB-1:0];
                splp_pkg::REG_POOL_HEIGHT: r_pool_height <= pwdata[SB-1:0];
                splp_pkg::REG_P_ORDER:     r_p_order     <= pwdata[SB-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            splp_pkg::REG_IMAGE_WIDTH: prdata = splp_pkg::PDATA_BITS'(r_image_width);
            splp_pkg::REG_POOL_WIDTH:  prdata = splp_pkg::PDATA_BITS'(r_pool_width);
            splp_pkg::REG_POOL_HEIGHT: prdata = splp_pkg::PDATA_BITS'(r_pool_height);
            splp_pkg::REG_P_ORDER:     prdata = splp_pkg::PDATA_BITS'(r_p_order);
            default:                   prdata = '0;
        endcase
    end

    assign iw_c = splp_pkg::clamp_width(r_image_width);
    assign pw_c = splp_pkg::clamp_small(r_pool_width);
    assign ph_c = splp_pkg::clamp_small(r_pool_height);
    assign p_c  = splp_pkg::clamp_small(r_p_order);

    // Datapath.
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Two's complement negation also gives the right magnitude for the most negative code.
    assign mag = i_sample[splp_pkg::SAMPLE_BITS-1] ?
                 (~i_sample + 1'b1) : i_sample;

    assign cand     = r_root | (RB'(1) << r_bit);
    assign pow_base = (r_state == S_IDLE) ? RB'(mag) : cand;

    splp_power u_power (
        .i_clk  (i_clk),
        .i_base (pow_base),
        .i_p    (p_c),
        .o_res  (pow_res)
    );

    splp_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (splp_pkg::MAX_WIDTH)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_ADD),
        .i_wr_addr (r_column_count),
        .i_wr_data (acc_sat),
        .i_rd_en   (accept),
        .i_rd_addr (r_column_count),
        .o_rd_data (ram_rd_data)
    );

    assign sum_ext = {1'b0, r_old} + {1'b0, pow_res.value};
    assign acc_sat = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    assign root_ok = !pow_res.over && (pow_res.value <= r_acc);

    assign incol    = INC_BITS'(r_column_count) * INC_BITS'(pw_c) + INC_BITS'(r_window_column);
    assign row_end  = (incol + INC_BITS'(1)) >= INC_BITS'(iw_c);
    assign col_done = ({1'b0, r_window_column} + SB'(1)) >= pw_c;
    assign row_done = ({1'b0, r_window_row} + SB'(1)) >= ph_c;
    assign win_done = col_done && row_done;

    // Position counters, updated once per item in the add step.
    always_comb begin
        n_column_count  = r_column_count;
        n_window_row    = r_window_row;
        n_window_column = r_window_column;
        if (r_state == S_ADD) begin
            if (r_last) begin
                n_column_count  = '0;
                n_window_row    = '0;
                n_window_column = '0;
            end else if (row_end) begin
                n_column_count  = '0;
                n_window_column = '0;
                n_window_row    = row_done ? 2'd0 : r_window_row + 2'd1;
            end else if (col_done) begin
                n_window_column = '0;
                n_column_count  = r_column_count + COL_BITS'(1);
            end else begin
                n_window_column = r_window_column + 2'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_POW;
            S_POW:  n_state = S_ADD;
            S_ADD:  n_state = win_done ? S_RSQ : S_IDLE;
            S_RSQ:  n_state = S_RPW;
            S_RPW:  n_state = S_RCMP;
            S_RCMP: n_state = (r_bit == '0) ? S_LOAD : S_RSQ;
            S_LOAD: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_column_count  <= '0;
            r_window_row    <= '0;
            r_window_column <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_column_count  <= n_column_count;
            r_window_row    <= n_window_row;
            r_window_column <= n_window_column;
            if (r_state == S_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_last_of_plane;
        end
        if (r_state == S_POW) begin
            // The first sample of a window starts a fresh sum.
            r_old <= (r_window_row == '0 && r_window_column == '0) ? '0 : ram_rd_data;
        end
        if (r_state == S_ADD) begin
            r_acc  <= acc_sat;
            r_root <= '0;
            r_bit  <= splp_pkg::BIT_IDX_W'(RB - 1);
        end
        if (r_state == S_RCMP) begin
            if (root_ok) begin
                r_root <= cand;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (r_state == S_LOAD && out_free) begin
            r_pooled   <= r_root;
            r_sat      <= (r_acc == '1);
            r_last_out <= r_last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_pooled            = r_pooled;
    assign o_saturated         = r_sat;
    assign o_last_of_plane_out = r_last_out;

    `SPLP_ASSERT_NXT(a_accept_starts_power, i_clk, i_rst_n, accept, r_state == S_POW)
    `SPLP_ASSERT_NXT(a_root_ends_in_load, i_clk, i_rst_n, r_state == S_RCMP && r_bit == '0, r_state == S_LOAD)
    `SPLP_ASSERT_NXT(a_load_fills_output, i_clk, i_rst_n, r_state == S_LOAD && out_free, r_out_valid && r_state == S_IDLE)
endmodule
`default_nettype wire

/* test/spatial_lp_pooling_checker.sv */
`timescale 1ns / 1ps
// Checker for the Lp pooling block: follows register writes, predicts each pooled item and compares.
module lp_pool_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic [splp_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  wire logic                              i_last_of_plane,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [splp_pkg::ROOT_BITS-1:0]    i_pooled,
    input  wire logic                              i_saturated,
    input  wire logic                              i_last_of_plane_out,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic                              i_pready,
    input  wire logic [splp_pkg::PADDR_BITS-1:0]   i_paddr,
    input  wire logic [splp_pkg::PDATA_BITS-1:0]   i_pwdata,
    output int                                     o_fail_count,
    output int                                     o_waiting
);
    import splp_pkg::*;

    typedef struct packed {
        logic [ROOT_BITS-1:0] pooled;
        logic                 saturated;
        logic                 last;
    } t_window_result;

    t_window_result        expected_windows[$];
    logic [SUM_BITS-1:0]   column_sums [MAX_WIDTH];
    logic [IW_BITS-1:0]    image_width;
    logic [SMALL_BITS-1:0] pool_width;
    logic [SMALL_BITS-1:0] pool_height;
    logic [SMALL_BITS-1:0] p_order;
    logic [COL_BITS-1:0]   column_count;
    logic [1:0]            window_row;
    logic [1:0]            window_column;
    int                    fail_count = 0;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Raises base to the p-th power; over flags a product that no longer fits in 64 bits.
    function automatic logic [SUM_BITS-1:0] raise_sat(input logic [SUM_BITS-1:0] base,
                                                      input int unsigned p, output bit over);
        logic [2*SUM_BITS-1:0] product;
        logic [SUM_BITS-1:0]   acc;
        acc = SUM_BITS'(1);
        over = 1'b0;
        for (int k = 0; k < p; k++) begin
            product = {{SUM_BITS{1'b0}}, acc} * {{SUM_BITS{1'b0}}, base};
            if (product[2*SUM_BITS-1:SUM_BITS] != '0) begin
                over = 1'b1;
                return '1;
            end
            acc = product[SUM_BITS-1:0];
        end
        return acc;
    endfunction

    // Largest root whose p-th power does not exceed the sum, built one bit at a time.
    function automatic logic [ROOT_BITS-1:0] norm_root(input logic [SUM_BITS-1:0] total,
                                                       input int unsigned p);
        logic [ROOT_BITS-1:0] root;
        logic [ROOT_BITS-1:0] trial;
        logic [SUM_BITS-1:0]  raised;
        bit                   over;
        root = '0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (ROOT_BITS'(1) << b);
            raised = raise_sat(SUM_BITS'(trial), p, over);
            if (!over && raised <= total) root = trial;
        end
        return root;
    endfunction

    task automatic accept_sample(input logic [SAMPLE_BITS-1:0] raw, input logic last);
        int unsigned         iw;
        int unsigned         pw;
        int unsigned         ph;
        int unsigned         p;
        int unsigned         in_column;
        logic [SAMPLE_BITS-1:0] mag;
        logic [SUM_BITS-1:0] term;
        logic [SUM_BITS-1:0] total;
        bit                  over;
        bit                  row_end;
        bit                  col_done;
        bit                  row_done;
        t_window_result      res;
        iw = clamp_to(image_width, MAX_WIDTH);
        pw = clamp_to(pool_width, 4);
        ph = clamp_to(pool_height, 4);
        p = clamp_to(p_order, 4);
        // The most negative sample negates to itself, which is its magnitude as unsigned.
        mag = raw[SAMPLE_BITS-1] ? -raw : raw;
        term = raise_sat(SUM_BITS'(mag), p, over);
        total = (window_row == 0 && window_column == 0) ? '0 : column_sums[column_count];
        total = (total > ~term) ? '1 : total + term;
        column_sums[column_count] = total;

        in_column = column_count * pw + window_column;
        row_end = (in_column + 1 >= iw);
        col_done = (window_column + 1 >= pw);
        row_done = (window_row + 1 >= ph);

        if (col_done && row_done) begin
            res.pooled = norm_root(total, p);
            res.saturated = (total == '1);
            res.last = last;
            expected_windows.push_back(res);
        end

        if (last) begin
            column_count = '0;
            window_row = '0;
            window_column = '0;
        end else if (row_end) begin
            column_count = '0;
            window_column = '0;
            window_row = row_done ? 2'd0 : window_row + 2'd1;
        end else if (col_done) begin
            window_column = '0;
            column_count = column_count + 1'b1;
        end else begin
            window_column = window_column + 2'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result want;
        if (!i_rst_n) begin
            image_width = IMAGE_WIDTH_RST;
            pool_width = POOL_WIDTH_RST;
            pool_height = POOL_HEIGHT_RST;
            p_order = P_ORDER_RST;
            column_count = '0;
            window_row = '0;
            window_column = '0;
            foreach (column_sums[i]) column_sums[i] = '0;
            expected_windows.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_BITS-1:2])
                    REG_IMAGE_WIDTH: image_width = i_pwdata[IW_BITS-1:0];
                    REG_POOL_WIDTH:  pool_width = i_pwdata[SMALL_BITS-1:0];
                    REG_POOL_HEIGHT: pool_height = i_pwdata[SMALL_BITS-1:0];
                    REG_P_ORDER:     p_order = i_pwdata[SMALL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_windows.size() == 0) begin
                    $error("pooled item %0d arrived with no window pending", i_pooled);
                    fail_count++;
                end else begin
                    want = expected_windows.pop_front();
                    check_field("pooled", 32'(want.pooled), 32'(i_pooled));
                    check_field("saturated", 32'(want.saturated), 32'(i_saturated));
                    check_field("last_of_plane_out", 32'(want.last), 32'(i_last_of_plane_out));
                end
            end
            if (i_in_valid && i_in_ready) accept_sample(i_sample, i_last_of_plane);
        end
        o_waiting <= expected_windows.size();
        o_fail_count <= fail_count;
    end
endmodule

/* test/spatial_lp_pooling_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the Lp pooling block: clock, reset, sample and register stimulus, verdict.
module spatial_lp_pooling_top_tb;
    import splp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_ITEMS  = 620;
    localparam int unsigned PLANE_CAP     = 160;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_last_of_plane = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [ROOT_BITS-1:0]          o_pooled;
    logic                          o_saturated;
    logic                          o_last_of_plane_out;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [PADDR_BITS-1:0]         paddr = '0;
    logic [PDATA_BITS-1:0]         pwdata = '0;
    logic [PDATA_BITS-1:0]         prdata;
    logic                          pready;

    int          fail_count;
    int          windows_waiting;
    int unsigned sent_items = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    spatial_lp_pooling_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .i_last_of_plane     (i_last_of_plane),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_pooled            (o_pooled),
        .o_saturated         (o_saturated),
        .o_last_of_plane_out (o_last_of_plane_out),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    lp_pool_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_sample            (i_sample),
        .i_last_of_plane     (i_last_of_plane),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_pooled            (o_pooled),
        .i_saturated         (o_saturated),
        .i_last_of_plane_out (o_last_of_plane_out),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_pready            (pready),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .o_fail_count        (fail_count),
        .o_waiting           (windows_waiting)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("spatial_lp_pooling_top_tb: FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, steady acceptance, or one long hold when asked.
    initial begin
        int unsigned k;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (k = 1; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned pick_small();
        return ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
    endfunction

    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 16);
        if (r < 80) return $urandom_range(17, 48);
        if (r < 85) return 0;
        if (r < 90) return 2047;
        return $urandom_range(1, 2047);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [SAMPLE_BITS-1:0] small_mag;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return '0;
                    3: return '1;
                    default: return 16'h0001;
                endcase
            end
            1, 2: begin
                small_mag = SAMPLE_BITS'($urandom_range(255));
                return $urandom_range(1) ? -small_mag : small_mag;
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Unused upper bits of a register write carry random data.
    function automatic logic [PDATA_BITS-1:0] with_noise(input int unsigned value,
                                                         input int unsigned bits);
        return ($urandom << bits) | value;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
        if (!steady && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= value;
        i_last_of_plane <= last;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
    endtask

    // Waits until every pending window has come out, then lets a late window finish.
    task automatic wait_until_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (windows_waiting != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [PDATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input int unsigned iw, input int unsigned pw,
                             input int unsigned ph, input int unsigned pr);
        wait_until_quiet();
        write_reg(REG_IMAGE_WIDTH, with_noise(iw, IW_BITS));
        write_reg(REG_POOL_WIDTH, with_noise(pw, SMALL_BITS));
        write_reg(REG_POOL_HEIGHT, with_noise(ph, SMALL_BITS));
        write_reg(REG_P_ORDER, with_noise(pr, SMALL_BITS));
    endtask

    initial begin
        int unsigned k;
        int unsigned phase;
        int unsigned rows;
        int unsigned count;
        int unsigned start_items;
        int unsigned iw;
        int unsigned pw;
        int unsigned ph;
        int unsigned pr;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sixteen most negative samples at p = 4 overflow the sum of a 4x4 window.
        configure(4, 4, 4, P_FOUR);
        for (k = 0; k < 16; k++) send_sample(16'h8000, k == 15);

        configure(1, 1, 1, P_ONE);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);

        // Zero and oversize register values count as their nearest legal size.
        configure(0, 0, 7, 0);
        for (k = 0; k < 4; k++) send_sample(random_sample(), k == 3);

        // Window shape and exponent change in the middle of a plane.
        configure(6, 2, 2, P_THREE);
        for (k = 0; k < 5; k++) send_sample(random_sample(), 1'b0);
        wait_until_quiet();
        write_reg(REG_P_ORDER, PDATA_BITS'(P_TWO));
        write_reg(REG_POOL_WIDTH, PDATA_BITS'(3));
        for (k = 0; k < 7; k++) send_sample(random_sample(), k == 6);

        // Every sample closes a window while the result side holds off, so the input stalls.
        configure(8, 1, 1, P_TWO);
        hold_req = 1'b1;
        for (k = 0; k < 40; k++) send_sample(random_sample(), k % 8 == 7);

        start_items = sent_items;
        phase = 0;
        while (sent_items - start_items < RANDOM_ITEMS) begin
            iw = pick_width();
            pw = pick_small();
            ph = pick_small();
            pr = pick_small();
            configure(iw, pw, ph, pr);
            steady = (phase >= 2 && phase < 5);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(99) < 80) begin
                    rows = fit(ph, 4) * $urandom_range(1, 2) + ($urandom_range(4) == 0);
                    count = fit(iw, MAX_WIDTH) * rows;
                    if (count > PLANE_CAP) count = PLANE_CAP;
                    for (k = 0; k < count; k++) send_sample(random_sample(), k == count - 1);
                end else begin
                    // Broken plane: short, with stray plane ends inside it.
                    count = $urandom_range(1, 20);
                    for (k = 0; k < count; k++) begin
                        send_sample(random_sample(), k == count - 1 || $urandom_range(9) == 0);
                    end
                end
            end
            phase++;
        end
        steady = 1'b0;

        wait_until_quiet();
        if (fail_count == 0) begin
            $display("spatial_lp_pooling_top_tb: PASS");
        end else begin
            $display("spatial_lp_pooling_top_tb: FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/splp_pkg.sv
hdl/splp_ram.sv
hdl/splp_power.sv
hdl/spatial_lp_pooling_top.sv
test/spatial_lp_pooling_checker.sv
test/spatial_lp_pooling_top_tb.sv
